// ===== rtl/rqr_pkg.sv =====
// ----------------------------------------------------------------------------
// rqr_pkg: shared types for the ready queue with removal
// Opcodes, status codes and the control word broadcast to every queue cell.
// ----------------------------------------------------------------------------
package rqr_pkg;

	typedef enum logic [1:0] {
		OP_ADD       = 2'd0,
		OP_YIELD     = 2'd1,
		OP_TERMINATE = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_EMPTY     = 2'd1,
		ST_FULL      = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	typedef struct packed {
		logic add;
		logic yield;
		logic term;
	} cell_ctrl_t;

endpackage

// ===== rtl/rqr_cell.sv =====
// ----------------------------------------------------------------------------
// rqr_cell: one slot of the ready queue
// Holds one identifier, loads at the tail, shifts toward the head on a pop
// or from the first matching slot onward on a removal.
// ----------------------------------------------------------------------------
module rqr_cell #(
	parameter int ID_WIDTH = 8,
	parameter int CNT_W    = 5,
	parameter int IDX      = 0
) (
	input  logic                  clk,
	input  rqr_pkg::cell_ctrl_t   ctrl,
	input  logic [CNT_W-1:0]      count,
	input  logic [ID_WIDTH-1:0]   id,
	input  logic [ID_WIDTH-1:0]   right_entry,
	input  logic                  seen_in,
	output logic                  seen_out,
	output logic [ID_WIDTH-1:0]   entry
);

	logic [ID_WIDTH-1:0] entry_q;
	logic [ID_WIDTH-1:0] entry_nxt;
	logic                occ;
	logic                tail;
	logic                hit;

	assign occ      = count > CNT_W'(IDX);
	assign tail     = count == CNT_W'(IDX);
	assign hit      = occ && (entry_q == id);
	assign seen_out = seen_in || hit;
	assign entry    = entry_q;

	always_comb begin
		entry_nxt = entry_q;
		if (ctrl.add && tail) begin
			entry_nxt = id;
		end else if (ctrl.yield || (ctrl.term && seen_out)) begin
			entry_nxt = right_entry;
		end
	end

	always_ff @(posedge clk) begin
		entry_q <= entry_nxt;
	end

endmodule

// ===== rtl/ready_queue_with_removal.sv =====
// ----------------------------------------------------------------------------
// ready_queue_with_removal: FIFO ready queue of thread identifiers
// Add at tail, pop head on yield, remove first match on terminate.
// ----------------------------------------------------------------------------
// Usage:
//   The slave channel takes one command word per handshake: opcode and thread
//   identifier. Every command gives exactly one result word on the master
//   channel: status, dispatched identifier, dispatch flag and occupancy.
//   The queue is a row of QUEUE_DEPTH cells. All cells compare the
//   identifier at once and shift toward the head together; the result is
//   registered and appears on the master channel in the cycle after
//   acceptance. Throughput is one command per cycle unless the receiver stalls.
//   The result sits in an output register; a new command is taken whenever
//   that register is empty or is being drained in the same cycle. While the
//   receiver stalls with a result pending, s_tready is low and the queue holds.
//   Reset empties the queue (fill count zero) and clears the result valid flag;
//   slot contents are not cleared and are never read before being written.
// ----------------------------------------------------------------------------
module ready_queue_with_removal #(
	parameter int QUEUE_DEPTH = 16,
	parameter int ID_WIDTH    = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// opcode, thread_id
	input  logic [((2 + ID_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	// status, dispatch_id, dispatch_valid, occupancy
	output logic [((3 + ID_WIDTH + $clog2(QUEUE_DEPTH + 1) + 7) / 8) * 8 - 1:0] m_tdata
);

	localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
	localparam int OUT_W  = 3 + ID_WIDTH + CNT_W;
	localparam int OUT_TW = ((OUT_W + 7) / 8) * 8;

	rqr_pkg::cell_ctrl_t ctrl;
	rqr_pkg::op_t        op;
	logic [ID_WIDTH-1:0] id;
	logic                go;
	logic                full;
	logic                empty;
	logic                found;

	logic [ID_WIDTH-1:0] ent  [QUEUE_DEPTH];
	logic                seen [QUEUE_DEPTH+1];

	logic [CNT_W-1:0]    count_q;
	logic [CNT_W-1:0]    count_nxt;
	rqr_pkg::status_t    status_nxt;
	logic [ID_WIDTH-1:0] disp_nxt;
	logic                dv_nxt;

	logic                out_valid_q;
	rqr_pkg::status_t    out_status_q;
	logic [ID_WIDTH-1:0] out_disp_q;
	logic                out_dv_q;
	logic [CNT_W-1:0]    out_occ_q;

	assign op       = rqr_pkg::op_t'(s_tdata[1:0]);
	assign id       = s_tdata[2 +: ID_WIDTH];
	assign s_tready = !out_valid_q || m_tready;
	assign go       = s_tvalid && s_tready;
	assign full     = count_q == CNT_W'(QUEUE_DEPTH);
	assign empty    = count_q == '0;
	assign found    = seen[QUEUE_DEPTH];
	assign seen[0]  = 1'b0;

	genvar gi;
	generate
		for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
			logic [ID_WIDTH-1:0] right;
			if (gi == QUEUE_DEPTH - 1) begin : g_last
				assign right = ent[gi];
			end else begin : g_mid
				assign right = ent[gi+1];
			end
			rqr_cell #(
				.ID_WIDTH (ID_WIDTH),
				.CNT_W    (CNT_W),
				.IDX      (gi)
			) u_cell (
				.clk         (clk),
				.ctrl        (ctrl),
				.count       (count_q),
				.id          (id),
				.right_entry (right),
				.seen_in     (seen[gi]),
				.seen_out    (seen[gi+1]),
				.entry       (ent[gi])
			);
		end
	endgenerate

	always_comb begin
		ctrl       = '0;
		count_nxt  = count_q;
		status_nxt = rqr_pkg::ST_OK;
		disp_nxt   = '0;
		dv_nxt     = 1'b0;
		case (op)
			rqr_pkg::OP_ADD: begin
				ctrl.add = go;
				if (full) begin
					status_nxt = rqr_pkg::ST_FULL;
				end else begin
					count_nxt = count_q + CNT_W'(1);
				end
			end
			rqr_pkg::OP_YIELD: begin
				if (empty) begin
					status_nxt = rqr_pkg::ST_EMPTY;
				end else begin
					ctrl.yield = go;
					disp_nxt   = ent[0];
					dv_nxt     = 1'b1;
					count_nxt  = count_q - CNT_W'(1);
				end
			end
			rqr_pkg::OP_TERMINATE: begin
				ctrl.term = go;
				if (found) begin
					count_nxt = count_q - CNT_W'(1);
				end else begin
					status_nxt = rqr_pkg::ST_NOT_FOUND;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (go) begin
				count_q <= count_nxt;
			end
			if (go) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			out_status_q <= status_nxt;
			out_disp_q   <= disp_nxt;
			out_dv_q     <= dv_nxt;
			out_occ_q    <= count_nxt;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_TW'({out_occ_q, out_dv_q, out_disp_q, out_status_q});

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("queue count exceeds depth");

	a_dispatch_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_dv_q |-> out_status_q == rqr_pkg::ST_OK)
		else $error("dispatch flagged with bad status");

	a_add_grows: assert property (@(posedge clk) disable iff (!arst_n)
		go && op == rqr_pkg::OP_ADD && !full |=> count_q == $past(count_q) + CNT_W'(1))
		else $error("add did not grow queue");

	a_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		go && op == rqr_pkg::OP_YIELD && empty |=>
		out_status_q == rqr_pkg::ST_EMPTY && !out_dv_q)
		else $error("yield on empty queue misreported");

	a_occ_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		go |=> out_occ_q == count_q)
		else $error("reported occupancy differs from count");

endmodule

// ===== tb/ready_queue_with_removal_tb.sv =====
// ----------------------------------------------------------------------------
// ready_queue_with_removal_tb: self-checking bench for the scheduler ready queue
// A short table of commands covers the empty, full and not-found cases, opcode
// decoding, removal from middle and tail, and a pop from the head. Random
// commands follow with a fill bias drawn per stretch. Each result word is
// checked against the table or a scheduler predictor. Both sides idle at random.
// ----------------------------------------------------------------------------
module ready_queue_with_removal_tb;

	localparam int QUEUE_DEPTH    = 16;
	localparam int ID_W           = 8;
	localparam int OCC_W          = $clog2(QUEUE_DEPTH + 1);
	localparam int S_W            = ((2 + ID_W + 7) / 8) * 8;
	localparam int M_W            = ((3 + ID_W + OCC_W + 7) / 8) * 8;
	localparam int NUM_DIRECTED   = 26;
	localparam int NUM_RANDOM     = 1800;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	typedef struct packed {
		logic [1:0]       status;
		logic [ID_W-1:0]  dispatch_id;
		logic             dispatch_valid;
		logic [OCC_W-1:0] occupancy;
	} sched_result_t;

	typedef struct packed {
		logic             checked;
		logic [1:0]       op;
		logic [ID_W-1:0]  id;
		logic [1:0]       status;
		logic [ID_W-1:0]  dispatch_id;
		logic             dispatch_valid;
		logic [OCC_W-1:0] occupancy;
	} cmd_row_t;

	localparam cmd_row_t DIRECTED_CMDS [NUM_DIRECTED] = '{
		'{1'b1, rqr_pkg::OP_YIELD,     8'h00, rqr_pkg::ST_EMPTY,     8'h00, 1'b0, 5'd0},
		'{1'b1, rqr_pkg::OP_TERMINATE, 8'h55, rqr_pkg::ST_NOT_FOUND, 8'h00, 1'b0, 5'd0},
		'{1'b1, OP_UNUSED,             8'hAA, rqr_pkg::ST_OK,        8'h00, 1'b0, 5'd0},
		'{1'b1, rqr_pkg::OP_ADD,       8'hFF, rqr_pkg::ST_OK,        8'h00, 1'b0, 5'd1},
		'{1'b1, rqr_pkg::OP_YIELD,     8'h00, rqr_pkg::ST_OK,        8'hFF, 1'b1, 5'd0},
		'{1'b0, rqr_pkg::OP_ADD,       8'h00, rqr_pkg::ST_OK,        8'h00, 1'b0, 5'd0},
		'{1'b0, rqr_pkg::OP_ADD,       8'h80, rqr_pkg::ST_OK,        8'h00, 1'b0, 5'd0},
		'{1'b0, rqr_pkg::OP_ADD,       8'h42, rqr_pkg::ST_OK,        8'h00, 1'b0, 5'd0},
		'{1'b0, rqr_pkg::OP_ADD,       8'h17, rqr_pkg::ST_OK,        8'h00, 1'b0, 5'd0},
		'{1'b0, rqr_pkg::OP_ADD,       8'h42, rqr_pkg::ST_OK,        8'h00, 1'b0, 5'd0},
		'{1'b0, rqr_pkg::OP_ADD,       8'hFE, rqr_pkg::ST_OK,        8'h00, 1'b0, 5'd0},
		'{1'b0, rqr_pkg::OP_ADD,       8'h01, rqr_pkg::ST_OK,        8'h00, 1'b0, 5'd0},
		'{1'b0, rqr_pkg::OP_ADD,       8'h99, rqr_pkg::ST_OK,        8'h00, 1'b0, 5'd0},
		'{1'b0, rqr_pkg::OP_ADD,       8'h42, rqr_pkg::ST_OK,        8'h00, 1'b0, 5'd0},
		'{1'b0, rqr_pkg::OP_ADD,       8'h7F, rqr_pkg::ST_OK,        8'h00, 1'b0, 5'd0},
		'{1'b0, rqr_pkg::OP_ADD,       8'h33, rqr_pkg::ST_OK,        8'h00, 1'b0, 5'd0},
		'{1'b0, rqr_pkg::OP_ADD,       8'hC5, rqr_pkg::ST_OK,        8'h00, 1'b0, 5'd0},
		'{1'b0, rqr_pkg::OP_ADD,       8'h0F, rqr_pkg::ST_OK,        8'h00, 1'b0, 5'd0},
		'{1'b0, rqr_pkg::OP_ADD,       8'hF0, rqr_pkg::ST_OK,        8'h00, 1'b0, 5'd0},
		'{1'b0, rqr_pkg::OP_ADD,       8'h5A, rqr_pkg::ST_OK,        8'h00, 1'b0, 5'd0},
		'{1'b0, rqr_pkg::OP_ADD,       8'hA5, rqr_pkg::ST_OK,        8'h00, 1'b0, 5'd0},
		'{1'b1, rqr_pkg::OP_ADD,       8'h3C, rqr_pkg::ST_FULL,      8'h00, 1'b0, 5'd16},
		'{1'b0, rqr_pkg::OP_TERMINATE, 8'h42, rqr_pkg::ST_OK,        8'h00, 1'b0, 5'd0},
		'{1'b1, rqr_pkg::OP_TERMINATE, 8'hEE, rqr_pkg::ST_NOT_FOUND, 8'h00, 1'b0, 5'd15},
		'{1'b0, rqr_pkg::OP_YIELD,     8'h00, rqr_pkg::ST_OK,        8'h00, 1'b0, 5'd0},
		'{1'b0, rqr_pkg::OP_TERMINATE, 8'hA5, rqr_pkg::ST_OK,        8'h00, 1'b0, 5'd0}
	};

	logic           clk;
	logic           arst_n;
	logic           s_tvalid;
	logic           s_tready;
	logic [S_W-1:0] s_tdata;
	logic           m_tvalid;
	logic           m_tready;
	logic [M_W-1:0] m_tdata;

	logic [ID_W-1:0] ready_ids[$];
	sched_result_t   expected_results[$];
	int              fail_count = 0;
	int              src_idle_max = 6;
	int              snk_idle_max = 6;
	int              stall_cycles = 0;

	ready_queue_with_removal #(
		.QUEUE_DEPTH(QUEUE_DEPTH),
		.ID_WIDTH(ID_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	function automatic sched_result_t apply_sched_cmd(input logic [1:0] op,
		input logic [ID_W-1:0] id);
		sched_result_t res;
		int hit;
		res = '0;
		res.status = rqr_pkg::ST_OK;
		case (op)
			rqr_pkg::OP_ADD: begin
				if (ready_ids.size() >= QUEUE_DEPTH)
					res.status = rqr_pkg::ST_FULL;
				else
					ready_ids.push_back(id);
			end
			rqr_pkg::OP_YIELD: begin
				if (ready_ids.size() == 0) begin
					res.status = rqr_pkg::ST_EMPTY;
				end else begin
					res.dispatch_id = ready_ids.pop_front();
					res.dispatch_valid = 1'b1;
				end
			end
			rqr_pkg::OP_TERMINATE: begin
				hit = -1;
				for (int i = 0; i < ready_ids.size(); i++)
					if (hit < 0 && ready_ids[i] == id)
						hit = i;
				if (hit < 0)
					res.status = rqr_pkg::ST_NOT_FOUND;
				else
					ready_ids.delete(hit);
			end
			default: ;
		endcase
		res.occupancy = OCC_W'(ready_ids.size());
		return res;
	endfunction

	task automatic issue_cmd(input logic [1:0] op, input logic [ID_W-1:0] id,
		output sched_result_t res);
		int gap;
		gap = $urandom_range(0, src_idle_max);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {{(S_W - 2 - ID_W){1'b0}}, id, op};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		res = apply_sched_cmd(op, id);
	endtask

	initial begin
		int stall;
		m_tready = 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			stall = $urandom_range(0, snk_idle_max);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		sched_result_t got;
		sched_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.status = m_tdata[1:0];
			got.dispatch_id = m_tdata[2 +: ID_W];
			got.dispatch_valid = m_tdata[2 + ID_W];
			got.occupancy = m_tdata[3 + ID_W +: OCC_W];
			if (expected_results.size() == 0) begin
				$error("result word with no command pending: %h", m_tdata);
				fail_count++;
			end else begin
				want = expected_results.pop_front();
				if (got.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, got.status);
					fail_count++;
				end
				if (got.dispatch_id !== want.dispatch_id) begin
					$error("dispatch_id: expected %h, got %h",
						want.dispatch_id, got.dispatch_id);
					fail_count++;
				end
				if (got.dispatch_valid !== want.dispatch_valid) begin
					$error("dispatch_valid: expected %0d, got %0d",
						want.dispatch_valid, got.dispatch_valid);
					fail_count++;
				end
				if (got.occupancy !== want.occupancy) begin
					$error("occupancy: expected %0d, got %0d",
						want.occupancy, got.occupancy);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	initial begin
		int n_random;
		int r;
		int add_pct;
		int coin;
		logic [1:0] op;
		logic [ID_W-1:0] id;
		sched_result_t res;
		cmd_row_t row;

		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < NUM_DIRECTED; i++) begin
			row = DIRECTED_CMDS[i];
			issue_cmd(row.op, row.id, res);
			if (row.checked)
				res = {row.status, row.dispatch_id, row.dispatch_valid, row.occupancy};
			expected_results.push_back(res);
		end

		n_random = 0;
		add_pct = 45;
		while (n_random < NUM_RANDOM) begin
			// switch idling and fill bias every stretch of commands
			if (n_random % 150 == 0) begin
				case ($urandom_range(0, 3))
					0: begin src_idle_max = 6; snk_idle_max = 6; end
					1: begin src_idle_max = 0; snk_idle_max = 0; end
					2: begin src_idle_max = 0; snk_idle_max = 6; end
					default: begin src_idle_max = 6; snk_idle_max = 0; end
				endcase
				case ($urandom_range(0, 2))
					0: add_pct = 20;
					1: add_pct = 45;
					default: add_pct = 70;
				endcase
			end
			r = $urandom_range(0, 99);
			if (r < 3)
				op = OP_UNUSED;
			else if (r < 3 + add_pct)
				op = rqr_pkg::OP_ADD;
			else if (r < 3 + add_pct + (97 - add_pct) / 2)
				op = rqr_pkg::OP_YIELD;
			else
				op = rqr_pkg::OP_TERMINATE;
			coin = $urandom_range(0, 99);
			if (op == rqr_pkg::OP_TERMINATE && ready_ids.size() != 0 && coin < 70)
				id = ready_ids[$urandom_range(0, ready_ids.size() - 1)];
			else if (coin < 85)
				id = ID_W'($urandom_range(0, 7));
			else
				id = ID_W'($urandom_range(0, 255));
			issue_cmd(op, id, res);
			expected_results.push_back(res);
			if (op != OP_UNUSED)
				n_random++;
		end
		s_tvalid <= 1'b0;

		while (expected_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
